// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file stbs_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hdl/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  localparam int unsigned STBS_DEPTH       = 1024;
  localparam int unsigned STBS_VALUE_WIDTH = 32;

  localparam int unsigned ENTRY_INDEX_W = 10;
  localparam int unsigned VALUE_PORT_W  = 32;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned RESULT_W      = 12;
  localparam int unsigned IN_DATA_W     = 80;
  localparam int unsigned OUT_DATA_W    = 16;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXACT = 2'd1,
    CMD_PRED  = 2'd2,
    CMD_LOWER = 2'd3
  } cmd_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_flags_t;

endpackage

`default_nettype wire

// ===== hdl/stbs_ram.sv =====
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/stbs_cmp.sv =====
`default_nettype none

module stbs_cmp import stbs_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = STBS_VALUE_WIDTH
) (
  input  wire logic [VALUE_WIDTH-1:0] entry_word,
  input  wire logic [VALUE_WIDTH-1:0] key_word,
  output cmp_flags_t                  flags
);

  always_comb begin
    flags.eq = (entry_word == key_word);
    flags.lt = ($signed(entry_word) < $signed(key_word));
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_table_binary_search.sv =====
// Binary search over a table of signed words held in an internal RAM.
// Input stream: s_tuser carries the command, s_tdata the entry index, the
// entry value and the search key. A write command stores one entry and gives
// no output transfer. The three query commands each give one output transfer
// with the echoed command in m_tuser and the signed result index in m_tdata.
// The APB register entry_count sets how many entries, from index zero, take
// part in a search; it is to be written only while the block is idle, and
// the block itself does not enforce this. A write command does not leave
// IDLE, so the block is ready again in the next cycle. A query runs one
// probe at a time through a single RAM read port and one shared comparator:
// each probe passes through ISSUE, for the registered RAM read, and then
// COMPARE, for the compare. s_tready stays low from the query's transfer
// until the result is loaded. The result sits in an output register; if
// the receiver stalls, a further write may still be taken, while a
// following query waits at its end. Reset clears the sequencer, the output
// valid and entry_count. Table contents are not cleared and an entry must
// be written before it is probed.
`default_nettype none

module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned DEPTH       = STBS_DEPTH,
  parameter int unsigned VALUE_WIDTH = STBS_VALUE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // entry_index [9:0], entry_value [41:10], search_key [73:42], zero pad.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // cmd [1:0].
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // result_index [11:0], zero pad.
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // query_kind [1:0].
  output logic [1:0]                 m_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = $clog2(DEPTH + 1) + 1;
  localparam int unsigned XW = VALUE_WIDTH + VALUE_PORT_W;

  typedef enum logic [1:0] {
    IDLE,
    ISSUE,
    COMPARE,
    FINISH
  } state_t;

  state_t                    state;
  cmd_t                      kind;
  logic [COUNT_W-1:0]        entry_count;
  logic [VALUE_WIDTH-1:0]    key;
  logic signed [IW-1:0]      lo;
  logic signed [IW-1:0]      hi;
  logic signed [IW-1:0]      mid;
  logic signed [IW-1:0]      res;

  logic [ENTRY_INDEX_W-1:0]  in_index;
  logic [VALUE_PORT_W-1:0]   in_value;
  logic [VALUE_PORT_W-1:0]   in_key;
  cmd_t                      in_cmd;
  logic                      accept;
  logic                      wr_en;
  logic [AW+ENTRY_INDEX_W-1:0] idx_ext;
  logic [XW-1:0]             value_ext;
  logic [XW-1:0]             key_ext;
  logic [31:0]               cnt_ext;
  logic signed [IW-1:0]      used;
  logic signed [IW-1:0]      mid_next;
  logic                      more;
  logic [VALUE_WIDTH-1:0]    rd_word;
  cmp_flags_t                flags;
  logic signed [IW+RESULT_W-1:0] res_ext;
  logic                      cfg_wr;

  assign in_index = s_tdata[ENTRY_INDEX_W-1:0];
  assign in_value = s_tdata[ENTRY_INDEX_W +: VALUE_PORT_W];
  assign in_key   = s_tdata[ENTRY_INDEX_W+VALUE_PORT_W +: VALUE_PORT_W];
  assign in_cmd   = cmd_t'(s_tuser);

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (in_cmd == CMD_WRITE) &&
                    (32'(in_index) < 32'(DEPTH));
  assign idx_ext   = (AW + ENTRY_INDEX_W)'(in_index);
  assign value_ext = XW'(in_value);
  assign key_ext   = XW'(in_key);

  assign cnt_ext = 32'(entry_count);
  assign used    = (cnt_ext > 32'(DEPTH)) ? IW'(DEPTH) : IW'(cnt_ext);

  assign more     = (kind == CMD_LOWER) ? (lo < hi) : (lo <= hi);
  assign mid_next = lo + ((hi - lo) >>> 1);

  assign res_ext = res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1] == REG_ENTRY_COUNT);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_ENTRY_COUNT) ?
                  APB_DATA_W'(entry_count) : '0;

  stbs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_ext[AW-1:0]),
    .wdata (value_ext[VALUE_WIDTH-1:0]),
    .raddr (mid_next[AW-1:0]),
    .rdata (rd_word)
  );

  stbs_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .entry_word (rd_word),
    .key_word   (key),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept && (in_cmd != CMD_WRITE)) begin
            kind  <= in_cmd;
            key   <= key_ext[VALUE_WIDTH-1:0];
            lo    <= '0;
            hi    <= (in_cmd == CMD_LOWER) ? used : used - IW'(1);
            res   <= '1;
            state <= ISSUE;
          end
        end
        ISSUE: begin
          if (more) begin
            mid   <= mid_next;
            state <= COMPARE;
          end else begin
            if (kind == CMD_PRED) begin
              res <= hi;
            end else if (kind == CMD_LOWER) begin
              res <= lo;
            end
            state <= FINISH;
          end
        end
        COMPARE: begin
          state <= ISSUE;
          case (kind)
            CMD_EXACT: begin
              if (flags.eq) begin
                res   <= mid;
                state <= FINISH;
              end else if (flags.lt) begin
                lo <= mid + IW'(1);
              end else begin
                hi <= mid - IW'(1);
              end
            end
            CMD_PRED: begin
              if (flags.lt || flags.eq) begin
                lo <= mid + IW'(1);
              end else begin
                hi <= mid - IW'(1);
              end
            end
            default: begin
              if (flags.lt) begin
                lo <= mid + IW'(1);
              end else begin
                hi <= mid;
              end
            end
          endcase
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'(res_ext[RESULT_W-1:0]);
            m_tuser  <= kind;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stbs_chk.sv =====
`default_nettype none

`include "assert_macros.svh"

module stbs_chk import stbs_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [IN_DATA_W-1:0] s_tdata,
  input wire logic [1:0]           s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [1:0]           m_tuser
);

  logic in_xfer;

  assign in_xfer = s_tvalid && s_tready;

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_NEXT(a_query_busy, clk, rst, in_xfer && s_tuser != CMD_WRITE, !s_tready)
  `ASSERT_NEXT(a_write_ready, clk, rst, in_xfer && s_tuser == CMD_WRITE, s_tready)
  `ASSERT_IMPLY(a_out_kind, clk, rst, m_tvalid, m_tuser != CMD_WRITE)

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (.*);

`default_nettype wire

// ===== tb/sorted_table_binary_search_tb.sv =====
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int INT_LOW = 32'sh8000_0000;
  localparam int INT_HIGH = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [APB_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

  typedef struct packed {
    cmd_t        kind;
    logic [11:0] index;
  } search_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // entry_index [9:0], entry_value [41:10], search_key [73:42], zero pad.
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // cmd [1:0].
  logic [1:0]            s_tuser = CMD_WRITE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // result_index [11:0], zero pad.
  logic [OUT_DATA_W-1:0] m_tdata;
  // query_kind [1:0].
  logic [1:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int             entry_words [STBS_DEPTH];
  bit             ramp_written [STBS_DEPTH];
  logic [10:0]    entry_count_q = '0;
  search_answer_t expected_results [$];
  bit             bursts_on = 1'b1;
  int             error_count = 0;

  sorted_table_binary_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [11:0] search_index(cmd_t kind, int key);
    int n;
    int lo;
    int hi;
    int mid;
    int found;
    n = (entry_count_q > 11'(STBS_DEPTH)) ? STBS_DEPTH : int'(entry_count_q);
    lo = 0;
    found = -1;
    case (kind)
      CMD_EXACT: begin
        hi = n - 1;
        while (lo <= hi && found < 0) begin
          mid = lo + (hi - lo) / 2;
          if (entry_words[mid] == key) found = mid;
          else if (entry_words[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      CMD_PRED: begin
        hi = n - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (entry_words[mid] <= key) lo = mid + 1;
          else hi = mid - 1;
        end
        found = hi;
      end
      default: begin
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (entry_words[mid] < key) lo = mid + 1;
          else hi = mid;
        end
        found = lo;
      end
    endcase
    return 12'(found);
  endfunction

  function automatic int ramp_word(int i);
    return i * 8 - 4096;
  endfunction

  function automatic int pick_key(int span);
    int base;
    base = (span > 0) ? entry_words[$urandom_range(0, span - 1)] : int'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return base;
      4: return base + 1;
      5: return base - 1;
      6: return INT_LOW;
      7: return INT_HIGH;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [ENTRY_INDEX_W-1:0] idx, int value, int key);
    search_answer_t answer;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= IN_DATA_W'({key, value, idx});
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_WRITE) begin
      entry_words[idx] = value;
    end else begin
      answer.kind = cmd;
      answer.index = search_index(cmd, key);
      expected_results.push_back(answer);
    end
  endtask

  task automatic query_random(int span);
    send_item(cmd_t'($urandom_range(1, 3)), ENTRY_INDEX_W'($urandom), $urandom, pick_key(span));
  endtask

  // Writes the ramp value into every entry that a full-depth search for this key probes.
  task automatic cover_probes(cmd_t kind, int key);
    int lo;
    int hi;
    int mid;
    bit done;
    lo = 0;
    hi = (kind == CMD_LOWER) ? STBS_DEPTH : STBS_DEPTH - 1;
    done = 1'b0;
    while (!done && ((kind == CMD_LOWER) ? (lo < hi) : (lo <= hi))) begin
      mid = lo + (hi - lo) / 2;
      if (!ramp_written[mid]) begin
        send_item(CMD_WRITE, ENTRY_INDEX_W'(mid), ramp_word(mid), $urandom);
        ramp_written[mid] = 1'b1;
      end
      if (kind == CMD_EXACT && ramp_word(mid) == key) done = 1'b1;
      else if (ramp_word(mid) < key || (kind == CMD_PRED && ramp_word(mid) == key))
        lo = mid + 1;
      else if (kind == CMD_LOWER) hi = mid;
      else hi = mid - 1;
    end
  endtask

  task automatic query_full_depth();
    cmd_t kind;
    int   key;
    kind = cmd_t'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0, 1: key = ramp_word(int'($urandom_range(0, STBS_DEPTH - 1)));
      2: key = ramp_word(int'($urandom_range(0, STBS_DEPTH - 1))) + 1;
      3: key = INT_LOW;
      4: key = INT_HIGH;
      default: key = $urandom;
    endcase
    cover_probes(kind, key);
    send_item(kind, ENTRY_INDEX_W'($urandom), $urandom, key);
  endtask

  task automatic wait_for_answers(int settle);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [10:0] value);
    wait_for_answers(SETTLE_CYCLES);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENTRY_COUNT_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entry_count_q = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_sorted_table(int n, bit narrow);
    int vals [STBS_DEPTH];
    int v;
    int j;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: v = INT_LOW;
        1: v = INT_HIGH;
        default: v = narrow ? int'($urandom_range(0, 30)) - 15 : int'($urandom);
      endcase
      j = i;
      while (j > 0 && vals[j - 1] > v) begin
        vals[j] = vals[j - 1];
        j--;
      end
      vals[j] = v;
    end
    for (int i = 0; i < n; i++) begin
      send_item(CMD_WRITE, ENTRY_INDEX_W'(i), vals[i], $urandom);
    end
  endtask

  task automatic test_empty_table();
    write_entry_count(11'd0);
    send_item(CMD_EXACT, '1, $urandom, INT_HIGH);
    send_item(CMD_PRED, '0, $urandom, INT_LOW);
    send_item(CMD_LOWER, '1, $urandom, 0);
  endtask

  task automatic test_directed_small();
    int   words [8];
    cmd_t probe_cmd [12];
    int   probe_key [12];
    words = '{INT_LOW, -5, -5, 0, 3, 3, 3, INT_HIGH};
    probe_cmd = '{CMD_EXACT, CMD_EXACT, CMD_EXACT, CMD_EXACT,
                  CMD_PRED, CMD_PRED, CMD_PRED, CMD_PRED,
                  CMD_LOWER, CMD_LOWER, CMD_LOWER, CMD_LOWER};
    probe_key = '{INT_LOW, INT_HIGH, 3, 1,
                  INT_LOW, -6, INT_HIGH, 2,
                  INT_LOW, INT_HIGH, 4, -5};
    for (int i = 0; i < 8; i++) begin
      send_item(CMD_WRITE, ENTRY_INDEX_W'(i), words[i], $urandom);
    end
    write_entry_count(11'd8);
    for (int i = 0; i < 12; i++) begin
      send_item(probe_cmd[i], ENTRY_INDEX_W'($urandom), $urandom, probe_key[i]);
    end
  endtask

  task automatic test_random_tables();
    int n;
    repeat (6) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      load_sorted_table(n, 1'($urandom_range(0, 1)));
      write_entry_count(($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, n)) : 11'(n));
      repeat (10) query_random(n);
    end
  endtask

  task automatic test_full_depth();
    write_entry_count(11'(STBS_DEPTH));
    repeat (8) query_full_depth();
    write_entry_count(11'h7ff);
    repeat (6) query_full_depth();
    write_entry_count(11'(STBS_DEPTH + 1));
    repeat (6) query_full_depth();
  endtask

  task automatic test_unsorted_table();
    load_sorted_table(16, 1'b1);
    write_entry_count(11'd16);
    repeat (20) begin
      send_item(CMD_WRITE, ENTRY_INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
      query_random(16);
      wait_for_answers(0);
    end
  endtask

  task automatic test_back_to_back();
    bursts_on = 1'b0;
    load_sorted_table(16, 1'b0);
    write_entry_count(11'd16);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(CMD_WRITE, ENTRY_INDEX_W'($urandom_range(16, STBS_DEPTH - 1)), $urandom,
                  $urandom);
      end
      query_random(16);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 10)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    search_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: query_kind %0d, result_index %0d",
               m_tuser, $signed(m_tdata[11:0]));
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("query_kind: expected %0d, actual %0d", want.kind, m_tuser);
          error_count++;
        end
        if (m_tdata[11:0] !== want.index) begin
          $error("result_index: expected %0d, actual %0d",
                 $signed(want.index), $signed(m_tdata[11:0]));
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_small();
    test_random_tables();
    test_full_depth();
    test_unsorted_table();
    test_back_to_back();
    wait_for_answers(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
